>>> rtl/cpu_ex_pkg.sv
// Package for the 6502 execute block: decoded operation codes, the decoded
// request type and the opcode decode functions. No dependencies.
package cpu_ex_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0] SpReset = 8'hFD;
  localparam logic [7:0] PReset  = 8'h24;
  localparam logic [7:0] FlagB   = 8'h10;
  localparam logic [7:0] FlagU   = 8'h20;

  typedef enum logic [4:0] {
    OP_NOP, OP_ORA, OP_AND, OP_EOR, OP_ADC, OP_SBC, OP_CMP, OP_CPX, OP_CPY,
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY, OP_SHM, OP_SHA,
    OP_DEC, OP_INC, OP_BIT, OP_PHP, OP_PHA, OP_PLA, OP_PLP, OP_JMP, OP_BR,
    OP_FLG, OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX
  } op_t;

  // extra ops that do not fit 5 bits are folded into OP_TSX variants
  typedef enum logic [2:0] {
    SUB_NONE, SUB_TXS, SUB_INX, SUB_DEX, SUB_INY, SUB_DEY
  } sub_t;

  typedef struct packed {
    op_t        op;
    sub_t       sub;
    logic [7:0] opcode;
    logic [7:0] m;
    logic [15:0] ea;
  } req_t;

  function automatic op_t decode(input logic [7:0] oc);
    op_t r;
    r = OP_NOP;
    case (oc) inside
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: r = OP_ORA;
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: r = OP_AND;
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: r = OP_EOR;
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: r = OP_ADC;
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: r = OP_SBC;
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: r = OP_CMP;
      8'hE0, 8'hE4, 8'hEC: r = OP_CPX;
      8'hC0, 8'hC4, 8'hCC: r = OP_CPY;
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: r = OP_LDA;
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: r = OP_LDX;
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: r = OP_LDY;
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: r = OP_STA;
      8'h86, 8'h8E, 8'h96: r = OP_STX;
      8'h84, 8'h8C, 8'h94: r = OP_STY;
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
      8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: r = OP_SHM;
      8'h0A, 8'h2A, 8'h4A, 8'h6A: r = OP_SHA;
      8'hC6, 8'hCE, 8'hD6, 8'hDE: r = OP_DEC;
      8'hE6, 8'hEE, 8'hF6, 8'hFE: r = OP_INC;
      8'h24, 8'h2C: r = OP_BIT;
      8'h08: r = OP_PHP;
      8'h48: r = OP_PHA;
      8'h68: r = OP_PLA;
      8'h28: r = OP_PLP;
      8'h4C, 8'h6C: r = OP_JMP;
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: r = OP_BR;
      8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8: r = OP_FLG;
      8'hAA: r = OP_TAX;
      8'hA8: r = OP_TAY;
      8'h8A: r = OP_TXA;
      8'h98: r = OP_TYA;
      8'hBA, 8'h9A, 8'hE8, 8'hCA, 8'hC8, 8'h88: r = OP_TSX;
      default: r = OP_NOP;
    endcase
    return r;
  endfunction

  function automatic sub_t decode_sub(input logic [7:0] oc);
    sub_t r;
    r = SUB_NONE;
    case (oc)
      8'h9A: r = SUB_TXS;
      8'hE8: r = SUB_INX;
      8'hCA: r = SUB_DEX;
      8'hC8: r = SUB_INY;
      8'h88: r = SUB_DEY;
      default: r = SUB_NONE;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cpu_ex_front.sv
// Front end: accept instruction requests and decode the opcode into an
// operation class. Depends on cpu_ex_pkg.
module cpu_ex_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_data,
  output logic              dec_valid,
  input  logic              dec_ready,
  output cpu_ex_pkg::req_t  dec_req
);

  logic valid;
  cpu_ex_pkg::req_t req;

  assign in_ready  = !valid || dec_ready;
  assign dec_valid = valid;
  assign dec_req   = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      req.op     <= cpu_ex_pkg::decode(in_data[7:0]);
      req.sub    <= cpu_ex_pkg::decode_sub(in_data[7:0]);
      req.opcode <= in_data[7:0];
      req.m      <= in_data[15:8];
      req.ea     <= in_data[31:16];
    end
  end

endmodule

>>> rtl/cpu_ex_queue.sv
// Small request queue between decode and execute. Depends on cpu_ex_pkg.
module cpu_ex_queue #(
  parameter int Depth = cpu_ex_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  cpu_ex_pkg::req_t  wr_req,
  output logic              rd_valid,
  input  logic              rd_ready,
  output cpu_ex_pkg::req_t  rd_req
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

  cpu_ex_pkg::req_t mem [Depth];
  logic [Aw-1:0] wptr, rptr;
  logic [Aw:0]   count;
  logic push, pop;

  assign wr_ready = (count != Depth[Aw:0]);
  assign rd_valid = (count != '0);
  assign rd_req   = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == Aw'(Depth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == Aw'(Depth - 1)) ? '0 : rptr + 1'b1;
      count <= count + (Aw+1)'(push) - (Aw+1)'(pop);
    end
    if (push) mem[wptr] <= wr_req;
  end

endmodule

>>> rtl/cpu_ex_back.sv
// Back end: execute a decoded request against A, X, Y, SP and P and
// register the result. Depends on cpu_ex_pkg.
module cpu_ex_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cpu_ex_pkg::req_t  req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [111:0]      out_data
);

  logic [7:0] a, x, y, sp, p;
  logic [7:0] a_next, x_next, y_next, sp_next, p_next;
  logic we, jt;
  logic [15:0] wa, tgt;
  logic [7:0] wd, m, v, r, opd;
  logic [8:0] sum;
  logic cond, fire, ovalid;
  logic [111:0] odata;

  assign req_ready = !ovalid || out_ready;
  assign fire      = req_valid && req_ready;
  assign out_valid = ovalid;
  assign out_data  = odata;

  always_comb begin
    a_next = a; x_next = x; y_next = y; sp_next = sp; p_next = p;
    we = 1'b0; jt = 1'b0; wa = '0; tgt = '0; wd = '0;
    m = req.m; r = '0; v = '0; sum = '0; cond = 1'b0;
    opd = (req.op == cpu_ex_pkg::OP_SBC) ? ~m : m;
    case (req.op)
      cpu_ex_pkg::OP_ORA: begin a_next = a | m; r = a_next; end
      cpu_ex_pkg::OP_AND: begin a_next = a & m; r = a_next; end
      cpu_ex_pkg::OP_EOR: begin a_next = a ^ m; r = a_next; end
      cpu_ex_pkg::OP_ADC, cpu_ex_pkg::OP_SBC: begin
        sum = {1'b0, a} + {1'b0, opd} + {8'b0, p[0]};
        a_next = sum[7:0]; r = a_next;
        p_next[0] = sum[8];
        p_next[6] = ~(a[7] ^ opd[7]) & (a[7] ^ sum[7]);
      end
      cpu_ex_pkg::OP_CMP, cpu_ex_pkg::OP_CPX, cpu_ex_pkg::OP_CPY: begin
        v = (req.op == cpu_ex_pkg::OP_CMP) ? a :
            (req.op == cpu_ex_pkg::OP_CPX) ? x : y;
        p_next[0] = v >= m; r = v - m;
      end
      cpu_ex_pkg::OP_LDA: begin a_next = m; r = m; end
      cpu_ex_pkg::OP_LDX: begin x_next = m; r = m; end
      cpu_ex_pkg::OP_LDY: begin y_next = m; r = m; end
      cpu_ex_pkg::OP_STA: begin we = 1'b1; wa = req.ea; wd = a; end
      cpu_ex_pkg::OP_STX: begin we = 1'b1; wa = req.ea; wd = x; end
      cpu_ex_pkg::OP_STY: begin we = 1'b1; wa = req.ea; wd = y; end
      cpu_ex_pkg::OP_SHM, cpu_ex_pkg::OP_SHA: begin
        v = (req.op == cpu_ex_pkg::OP_SHM) ? m : a;
        case (req.opcode[6:5])
          2'd0: begin r = {v[6:0], 1'b0}; p_next[0] = v[7]; end
          2'd1: begin r = {v[6:0], p[0]}; p_next[0] = v[7]; end
          2'd2: begin r = {1'b0, v[7:1]}; p_next[0] = v[0]; end
          default: begin r = {p[0], v[7:1]}; p_next[0] = v[0]; end
        endcase
        if (req.op == cpu_ex_pkg::OP_SHM) begin
          we = 1'b1; wa = req.ea; wd = r;
        end else begin
          a_next = r;
        end
      end
      cpu_ex_pkg::OP_DEC: begin r = m - 8'd1; we = 1'b1; wa = req.ea; wd = r; end
      cpu_ex_pkg::OP_INC: begin r = m + 8'd1; we = 1'b1; wa = req.ea; wd = r; end
      cpu_ex_pkg::OP_PHP, cpu_ex_pkg::OP_PHA: begin
        we = 1'b1; wa = {8'h01, sp};
        wd = (req.op == cpu_ex_pkg::OP_PHP) ?
             (p | cpu_ex_pkg::FlagB | cpu_ex_pkg::FlagU) : a;
        sp_next = sp - 8'd1;
      end
      cpu_ex_pkg::OP_PLA: begin sp_next = sp + 8'd1; a_next = m; r = m; end
      cpu_ex_pkg::OP_PLP: begin sp_next = sp + 8'd1; p_next = m; end
      cpu_ex_pkg::OP_JMP: begin jt = 1'b1; tgt = req.ea; end
      cpu_ex_pkg::OP_BR: begin
        case (req.opcode[7:6])
          2'd0: cond = p[7];
          2'd1: cond = p[6];
          2'd2: cond = p[0];
          default: cond = p[1];
        endcase
        if (cond == req.opcode[5]) begin jt = 1'b1; tgt = req.ea; end
      end
      cpu_ex_pkg::OP_FLG: begin
        case (req.opcode[7:6])
          2'd0: p_next[0] = req.opcode[5];
          2'd1: p_next[2] = req.opcode[5];
          2'd2: p_next[6] = 1'b0;
          default: p_next[3] = req.opcode[5];
        endcase
      end
      cpu_ex_pkg::OP_TAX: begin x_next = a; r = a; end
      cpu_ex_pkg::OP_TAY: begin y_next = a; r = a; end
      cpu_ex_pkg::OP_TXA: begin a_next = x; r = x; end
      cpu_ex_pkg::OP_TYA: begin a_next = y; r = y; end
      cpu_ex_pkg::OP_TSX: begin
        case (req.sub)
          cpu_ex_pkg::SUB_TXS: sp_next = x;
          cpu_ex_pkg::SUB_INX: begin x_next = x + 8'd1; r = x_next; end
          cpu_ex_pkg::SUB_DEX: begin x_next = x - 8'd1; r = x_next; end
          cpu_ex_pkg::SUB_INY: begin y_next = y + 8'd1; r = y_next; end
          cpu_ex_pkg::SUB_DEY: begin y_next = y - 8'd1; r = y_next; end
          default: begin x_next = sp; r = sp; end
        endcase
      end
      default: ;
    endcase
    // N and Z follow the result for every class that sets them, except BIT and PLP
    if ((req.op != cpu_ex_pkg::OP_NOP) && (req.op != cpu_ex_pkg::OP_STA) &&
        (req.op != cpu_ex_pkg::OP_STX) && (req.op != cpu_ex_pkg::OP_STY) &&
        (req.op != cpu_ex_pkg::OP_PHP) && (req.op != cpu_ex_pkg::OP_PHA) &&
        (req.op != cpu_ex_pkg::OP_PLP) && (req.op != cpu_ex_pkg::OP_JMP) &&
        (req.op != cpu_ex_pkg::OP_BR) && (req.op != cpu_ex_pkg::OP_FLG) &&
        (req.op != cpu_ex_pkg::OP_BIT) &&
        !((req.op == cpu_ex_pkg::OP_TSX) && (req.sub == cpu_ex_pkg::SUB_TXS))) begin
      p_next[7] = r[7];
      p_next[1] = (r == 8'd0);
    end
    if (req.op == cpu_ex_pkg::OP_BIT) begin
      p_next[7] = m[7];
      p_next[6] = m[6];
      p_next[1] = ((a & m) == 8'd0);
    end
    p_next = (p_next | cpu_ex_pkg::FlagU) & ~cpu_ex_pkg::FlagB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      a <= '0; x <= '0; y <= '0;
      sp <= cpu_ex_pkg::SpReset;
      p  <= cpu_ex_pkg::PReset;
    end else begin
      if (req_ready) ovalid <= req_valid;
      if (fire) begin
        a <= a_next; x <= x_next; y <= y_next; sp <= sp_next; p <= p_next;
      end
    end
    if (fire) begin
      odata <= {30'd0, p_next, sp_next, y_next, x_next, a_next,
                tgt, jt, wd, wa, we};
    end
  end

endmodule

>>> rtl/cpu_8bit_instruction_execute.sv
// Top level of the 6502 execute block: decode front end, request queue and
// execute back end. Depends on cpu_ex_pkg, cpu_ex_front, cpu_ex_queue, cpu_ex_back.
//
//  channel | direction | tdata fields (low bit up)
//  s_axis  | in        | opcode[7:0] operand_byte[15:8] effective_address[31:16]
//  m_axis  | out       | write_enable, write_address, write_data, jump_taken,
//          |           | jump_target, acc_out, x_out, y_out, sp_out, status_out
//
// One instruction per cycle sustained while m_axis takes results; a result passes
// through the decode register, the queue and the execute result register.
// The register file update (A, X, Y, SP, P) closes in the execute stage.
// Reset clears the pipeline and loads SP = 0xFD, P = 0x24.
// A stall at m_axis holds the result; the queue lets decode keep taking requests until it is full.
module cpu_8bit_instruction_execute #(
  parameter int QueueDepth = cpu_ex_pkg::QueueDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode, operand_byte, effective_address
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_enable[0], write_address[16:1], write_data[24:17], jump_taken[25],
  // jump_target[41:26], acc_out[49:42], x_out[57:50], y_out[65:58],
  // sp_out[73:66], status_out[81:74], zero fill to 112
  output logic [111:0] m_axis_tdata
);

  logic dec_valid, dec_ready, q_valid, q_ready;
  cpu_ex_pkg::req_t dec_req, q_req;

  cpu_ex_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .dec_valid, .dec_ready, .dec_req
  );

  cpu_ex_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_valid(dec_valid), .wr_ready(dec_ready), .wr_req(dec_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_req(q_req)
  );

  // back end packs the fields low and drives the byte fill with zeros
  cpu_ex_back u_back (
    .clk, .rst,
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
  );

endmodule

>>> dv/cpu_ex_checker.sv
`timescale 1ns / 100ps
// Checker for the 6502 execute block: predicts each result from the accepted
// requests with its own register copy and compares. Depends on nothing else.
module cpu_ex_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic        we;
    logic [15:0] wa;
    logic [7:0]  wd;
    logic        jt;
    logic [15:0] tgt;
    logic [7:0]  a, x, y, sp, p;
  } exec_result_t;

  localparam logic [7:0] FC = 8'h01, FZ = 8'h02, FI = 8'h04, FD = 8'h08;
  localparam logic [7:0] FB = 8'h10, FU = 8'h20, FV = 8'h40, FN = 8'h80;

  logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
  exec_result_t result_q[$];

  function automatic logic [7:0] nz(input logic [7:0] v);
    cpu_p[7] = v[7];
    cpu_p[1] = (v == 8'h00);
    return v;
  endfunction

  function automatic void add_c(input logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, cpu_a} + {1'b0, m} + {8'h00, cpu_p[0]};
    cpu_p[0] = s[8];
    cpu_p[6] = ~(cpu_a[7] ^ m[7]) & (cpu_a[7] ^ s[7]);
    cpu_a = nz(s[7:0]);
  endfunction

  function automatic void cmp(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    cpu_p[0] = (r >= m);
    void'(nz(d));
  endfunction

  function automatic logic [7:0] shift(input logic [1:0] kind, input logic [7:0] v);
    logic [7:0] r;
    logic ci;
    ci = cpu_p[0];
    if (!kind[1]) begin
      cpu_p[0] = v[7];
      r = {v[6:0], kind[0] & ci};
    end else begin
      cpu_p[0] = v[0];
      r = {kind[0] & ci, v[7:1]};
    end
    return nz(r);
  endfunction

  // Execute one instruction on the shadow registers and queue its result.
  function automatic void execute_instr(input logic [31:0] d);
    logic [7:0] op, m;
    logic [15:0] ea;
    exec_result_t r;
    logic cond;
    op = d[7:0]; m = d[15:8]; ea = d[31:16];
    r = '0;
    case (op)
      8'h01, 8'h05, 8'h09, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D: cpu_a = nz(cpu_a | m);
      8'h21, 8'h25, 8'h29, 8'h2D, 8'h31, 8'h35, 8'h39, 8'h3D: cpu_a = nz(cpu_a & m);
      8'h41, 8'h45, 8'h49, 8'h4D, 8'h51, 8'h55, 8'h59, 8'h5D: cpu_a = nz(cpu_a ^ m);
      8'h61, 8'h65, 8'h69, 8'h6D, 8'h71, 8'h75, 8'h79, 8'h7D: add_c(m);
      8'hE1, 8'hE5, 8'hE9, 8'hED, 8'hF1, 8'hF5, 8'hF9, 8'hFD: add_c(~m);
      8'hC1, 8'hC5, 8'hC9, 8'hCD, 8'hD1, 8'hD5, 8'hD9, 8'hDD: cmp(cpu_a, m);
      8'hE0, 8'hE4, 8'hEC: cmp(cpu_x, m);
      8'hC0, 8'hC4, 8'hCC: cmp(cpu_y, m);
      8'hA1, 8'hA5, 8'hA9, 8'hAD, 8'hB1, 8'hB5, 8'hB9, 8'hBD: cpu_a = nz(m);
      8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: cpu_x = nz(m);
      8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: cpu_y = nz(m);
      8'h81, 8'h85, 8'h8D, 8'h91, 8'h95, 8'h99, 8'h9D: begin
        r.we = 1; r.wa = ea; r.wd = cpu_a;
      end
      8'h86, 8'h8E, 8'h96: begin
        r.we = 1; r.wa = ea; r.wd = cpu_x;
      end
      8'h84, 8'h8C, 8'h94: begin
        r.we = 1; r.wa = ea; r.wd = cpu_y;
      end
      8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
      8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
        r.we = 1; r.wa = ea; r.wd = shift(op[6:5], m);
      end
      8'h0A, 8'h2A, 8'h4A, 8'h6A: cpu_a = shift(op[6:5], cpu_a);
      8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
        r.we = 1; r.wa = ea; r.wd = nz(m - 8'd1);
      end
      8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
        r.we = 1; r.wa = ea; r.wd = nz(m + 8'd1);
      end
      8'h24, 8'h2C: begin
        cpu_p[7] = m[7]; cpu_p[6] = m[6]; cpu_p[1] = ((cpu_a & m) == 8'h00);
      end
      8'h08, 8'h48: begin
        r.we = 1; r.wa = {8'h01, cpu_sp};
        r.wd = (op == 8'h08) ? (cpu_p | FB | FU) : cpu_a;
        cpu_sp = cpu_sp - 8'd1;
      end
      8'h68: begin
        cpu_sp = cpu_sp + 8'd1; cpu_a = nz(m);
      end
      8'h28: begin
        cpu_sp = cpu_sp + 8'd1; cpu_p = (m & ~FB) | FU;
      end
      8'h4C, 8'h6C: begin
        r.jt = 1; r.tgt = ea;
      end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: begin
        case (op[7:6])
          2'd0: cond = cpu_p[7];
          2'd1: cond = cpu_p[6];
          2'd2: cond = cpu_p[0];
          default: cond = cpu_p[1];
        endcase
        if (cond == op[5]) begin
          r.jt = 1; r.tgt = ea;
        end
      end
      8'h18: cpu_p = cpu_p & ~FC;
      8'h38: cpu_p = cpu_p | FC;
      8'h58: cpu_p = cpu_p & ~FI;
      8'h78: cpu_p = cpu_p | FI;
      8'hB8: cpu_p = cpu_p & ~FV;
      8'hD8: cpu_p = cpu_p & ~FD;
      8'hF8: cpu_p = cpu_p | FD;
      8'hAA: cpu_x = nz(cpu_a);
      8'hA8: cpu_y = nz(cpu_a);
      8'h8A: cpu_a = nz(cpu_x);
      8'h98: cpu_a = nz(cpu_y);
      8'hBA: cpu_x = nz(cpu_sp);
      8'h9A: cpu_sp = cpu_x;
      8'hE8: cpu_x = nz(cpu_x + 8'd1);
      8'hCA: cpu_x = nz(cpu_x - 8'd1);
      8'hC8: cpu_y = nz(cpu_y + 8'd1);
      8'h88: cpu_y = nz(cpu_y - 8'd1);
      default: ;
    endcase
    cpu_p = (cpu_p | FU) & ~FB;
    r.a = cpu_a; r.x = cpu_x; r.y = cpu_y; r.sp = cpu_sp; r.p = cpu_p;
    result_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    exec_result_t e;
    if (rst) begin
      cpu_a <= 8'h00; cpu_x <= 8'h00; cpu_y <= 8'h00;
      cpu_sp <= 8'hFD; cpu_p <= 8'h24;
      fail_count <= 0;
      result_q.delete();
      pending = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          e = result_q.pop_front();
          check_field("write_enable",  16'(e.we),  16'(m_axis_tdata[0]));
          check_field("write_address", e.wa,       m_axis_tdata[16:1]);
          check_field("write_data",    16'(e.wd),  16'(m_axis_tdata[24:17]));
          check_field("jump_taken",    16'(e.jt),  16'(m_axis_tdata[25]));
          check_field("jump_target",   e.tgt,      m_axis_tdata[41:26]);
          check_field("acc_out",       16'(e.a),   16'(m_axis_tdata[49:42]));
          check_field("x_out",         16'(e.x),   16'(m_axis_tdata[57:50]));
          check_field("y_out",         16'(e.y),   16'(m_axis_tdata[65:58]));
          check_field("sp_out",        16'(e.sp),  16'(m_axis_tdata[73:66]));
          check_field("status_out",    16'(e.p),   16'(m_axis_tdata[81:74]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) execute_instr(s_axis_tdata);
      pending = result_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Top of the 6502 execute block testbench: clock, reset, request stimulus and
// verdict. Depends on cpu_8bit_instruction_execute and cpu_ex_checker.
module testbench;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  bit           hold_sink = 1'b0;
  bit           stim_done = 1'b0;

  always #5 clk = ~clk;

  cpu_8bit_instruction_execute i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  cpu_ex_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Mostly short gaps, now and then a long one, often none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_req(input logic [7:0] op, input logic [7:0] m, input logic [15:0] ea);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ea, m, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Bias toward opcodes the block executes; leave some room for undefined ones.
  function automatic logic [7:0] pick_opcode();
    logic [7:0] ops[$] = '{8'h69, 8'hE9, 8'hC9, 8'hE0, 8'hC0, 8'hA9, 8'hA2, 8'hA0,
      8'h09, 8'h29, 8'h49, 8'h85, 8'h86, 8'h84, 8'h06, 8'h26, 8'h46, 8'h66,
      8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'hC6, 8'hE6, 8'h24, 8'h08, 8'h48, 8'h68,
      8'h28, 8'h4C, 8'h6C, 8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0,
      8'hF0, 8'h18, 8'h38, 8'h58, 8'h78, 8'hB8, 8'hD8, 8'hF8, 8'hAA, 8'hA8,
      8'h8A, 8'h98, 8'hBA, 8'h9A, 8'hE8, 8'hCA, 8'hC8, 8'h88};
    if ($urandom_range(0, 9) < 7) return ops[$urandom_range(0, ops.size() - 1)];
    return 8'($urandom);
  endfunction

  // Receiver: random stalls, plus a long hold while the sender keeps pushing.
  initial begin
    int g;
    while (!stim_done || pending != 0) begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        g = gap_len();
        if (g > 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  initial begin
    #10_000_000;
    $display("[cpu_8bit_instruction_execute] ERROR");
    $finish;
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, ADC/SBC carry and overflow, compares, stack wrap.
    send_req(8'h69, 8'h7F, 16'h0000);  // 0 + 7F
    send_req(8'h69, 8'h01, 16'hFFFF);  // overflow into sign
    send_req(8'h69, 8'hFF, 16'h0000);  // carry out
    send_req(8'hE9, 8'h80, 16'h0000);
    send_req(8'hE9, 8'h00, 16'h0000);
    send_req(8'hC9, 8'hFF, 16'h0000);  // unsigned compare
    send_req(8'hE0, 8'h00, 16'h0000);
    send_req(8'hC0, 8'h01, 16'h0000);
    send_req(8'h24, 8'hC0, 16'h0000);  // bit test
    send_req(8'h08, 8'h00, 16'h0000);  // push status with B and U
    send_req(8'h48, 8'h00, 16'h0000);
    send_req(8'h68, 8'h80, 16'h0000);  // pull sets N
    send_req(8'h28, 8'hFF, 16'h0000);  // pull status drops B
    send_req(8'hA2, 8'h00, 16'h0000);
    send_req(8'h9A, 8'h00, 16'h0000);  // SP = 0, then push wraps
    send_req(8'h48, 8'h00, 16'h0000);
    send_req(8'h68, 8'h00, 16'h0000);  // pull wraps back
    send_req(8'hBA, 8'h00, 16'h0000);
    send_req(8'h4C, 8'h00, 16'hFFFF);
    send_req(8'h6C, 8'h00, 16'h8000);
    send_req(8'hF0, 8'h00, 16'h1234);
    send_req(8'h6A, 8'h00, 16'h0000);
    send_req(8'h00, 8'hFF, 16'hFFFF);  // left-out opcode acts as NOP
    send_req(8'h20, 8'hFF, 16'hFFFF);
    send_req(8'hFF, 8'h55, 16'hAAAA);
    // Random part with one long receiver hold and one drain pause.
    for (n = 0; n < 2000; n++) begin
      if (n == 500) hold_sink = 1'b1;
      if (n == 1200) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_req(pick_opcode(), 8'($urandom), 16'($urandom));
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[cpu_8bit_instruction_execute] OK");
    end else begin
      $display("[cpu_8bit_instruction_execute] ERROR");
    end
    $finish;
  end

endmodule
